// ===== rtl/itpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itpd_pkg
// Shared sizes, character codes and cell control types for the
// integer to padded decimal converter.
// ----------------------------------------------------------------------------
package itpd_pkg;

  localparam int VALUE_BITS = 32;
  // Width of the value field; capped at 64 bits with the sign in the top bit.
  localparam int VAL_W      = (VALUE_BITS >= 64) ? 64 : VALUE_BITS + 1;
  // Magnitude of a two's complement value always fits in VAL_W unsigned bits.
  localparam int MAG_W      = VAL_W;
  // Decimal digits needed for MAG_W bits (log10(2) ~ 0.30103).
  localparam int NDIG       = (MAG_W * 30103) / 100000 + 1;
  localparam int CNT_W      = $clog2(MAG_W + 1);
  localparam int NDIG_W     = $clog2(NDIG + 1);
  localparam int PAD_W      = 6;
  localparam int CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/itpd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itpd_if
// Valid/ready channels: number words in, character words out.
// ----------------------------------------------------------------------------
interface itpd_in_if import itpd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value;
  logic [PAD_W-1:0]        pad_width;

  modport source (output valid, value, pad_width, input ready);
  modport sink   (input valid, value, pad_width, output ready);
endinterface

interface itpd_out_if import itpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;

  modport source (output valid, character, last_char, input ready);
  modport sink   (input valid, character, last_char, output ready);
endinterface
`default_nettype wire

// ===== rtl/itpd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itpd_cell
// One BCD digit of the shift-add-3 chain. Dabbles a bit in from the lower
// neighbor, or moves whole digits one place up for alignment and output.
// ----------------------------------------------------------------------------
module itpd_cell import itpd_pkg::*; (
  input  wire logic       clk_i,
  input  wire cell_ctl_t  ctl_i,
  input  wire logic       bit_i,
  input  wire logic [3:0] digit_i,
  output logic            bit_o,
  output logic [3:0]      digit_o
);

  logic [3:0] digit_q;
  logic [3:0] digit_d;
  logic [3:0] adj;

  // Add 3 when the digit would pass nine after doubling.
  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign bit_o   = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    case (ctl_i.op)
      CELL_CLEAR:  digit_d = 4'd0;
      CELL_DABBLE: digit_d = {adj[2:0], bit_i};
      CELL_SHIFT:  digit_d = digit_i;
      default:     digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule
`default_nettype wire

// ===== rtl/int_to_padded_decimal.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_padded_decimal
// Converts a two's complement integer to zero padded decimal ASCII text,
// one character word per output handshake, most significant first.
// ----------------------------------------------------------------------------
//
//  channel | dir | word contents              | accepted when
//  --------+-----+----------------------------+------------------------
//  in_i    | in  | value, pad_width           | in_i.valid & in_i.ready
//  out_o   | out | character, last_char       | out_o.valid & out_o.ready
//
// Sequence: a number is accepted while idle, then its MAG_W magnitude bits
// pass through the chain of BCD cells one bit per cycle, leading zero digits
// are dropped in the alignment state (up to NDIG-1, keeping at least one),
// a preparation state follows, then characters are emitted one per handshake.
// The chain is the only datapath, so numbers go one at a time; in_i.ready is
// high only while idle.
// Reset: asynchronous, active low; clears the sequencer and output register.
// Stalls: a held output word freezes the emitting states until it is taken;
// conversion and alignment never wait.
// ----------------------------------------------------------------------------
module int_to_padded_decimal import itpd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  itpd_in_if.sink     in_i,
  itpd_out_if.source  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_PREP,
    ST_SIGN,
    ST_PAD,
    ST_DIGIT
  } state_e;

  state_e              state_q;
  logic [MAG_W-1:0]    shift_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [NDIG_W-1:0]   ndig_q;
  logic                neg_q;
  logic [PAD_W-1:0]    pad_q;
  logic [PAD_W-1:0]    zeros_q;
  logic                out_valid_q;
  logic [CHAR_W-1:0]   out_char_q;
  logic                out_last_q;

  cell_ctl_t           cell_ctl;
  logic                carry [NDIG+1];
  logic [3:0]          dig   [NDIG+1];
  logic [3:0]          top_digit;

  logic [VAL_W-1:0]    raw;
  logic                raw_neg;
  logic [MAG_W-1:0]    raw_mag;
  logic [PAD_W-1:0]    natural;
  logic                slot_free;
  logic                emit_word;

  // Magnitude of the incoming value, negated without overflow.
  assign raw       = in_i.value;
  assign raw_neg   = raw[VAL_W-1];
  assign raw_mag   = raw_neg ? (~raw + MAG_W'(1)) : raw;

  assign natural   = PAD_W'(ndig_q) + PAD_W'(neg_q);
  assign slot_free = !out_valid_q || out_o.ready;
  assign top_digit = dig[NDIG];

  // An emitting state loads a fresh word whenever the output slot is free.
  assign emit_word = slot_free && (state_q inside {ST_SIGN, ST_PAD, ST_DIGIT});

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.character = out_char_q;
  assign out_o.last_char = out_last_q;

  // Chain of BCD cells: lowest takes magnitude bits, digits move upward.
  assign carry[0] = shift_q[MAG_W-1];
  assign dig[0]   = 4'd0;

  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    itpd_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .bit_i   (carry[i]),
      .digit_i (dig[i]),
      .bit_o   (carry[i+1]),
      .digit_o (dig[i+1])
    );
  end

  // Cell command for this cycle.
  always_comb begin
    cell_ctl.op = CELL_HOLD;
    case (state_q)
      ST_IDLE:  if (in_i.valid) cell_ctl.op = CELL_CLEAR;
      ST_CONV:  cell_ctl.op = CELL_DABBLE;
      ST_ALIGN: if (top_digit == 4'd0 && ndig_q > NDIG_W'(1)) cell_ctl.op = CELL_SHIFT;
      ST_DIGIT: if (slot_free) cell_ctl.op = CELL_SHIFT;
      default:  cell_ctl.op = CELL_HOLD;
    endcase
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      ndig_q      <= '0;
      shift_q     <= '0;
      neg_q       <= 1'b0;
      pad_q       <= '0;
      zeros_q     <= '0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // Hold the output word until taken; emitting states load a fresh one.
      out_valid_q <= emit_word || (out_valid_q && !out_o.ready);

      case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            shift_q <= raw_mag;
            neg_q   <= raw_neg;
            pad_q   <= in_i.pad_width;
            cnt_q   <= CNT_W'(MAG_W);
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          // Advance one magnitude bit into the chain.
          shift_q <= {shift_q[MAG_W-2:0], 1'b0};
          cnt_q   <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            ndig_q  <= NDIG_W'(NDIG);
            state_q <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          // Drop leading zero digits, keeping at least one.
          if (top_digit == 4'd0 && ndig_q > NDIG_W'(1)) begin
            ndig_q <= ndig_q - NDIG_W'(1);
          end else begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          zeros_q <= (pad_q > natural) ? pad_q - natural : '0;
          if (neg_q)                state_q <= ST_SIGN;
          else if (pad_q > natural) state_q <= ST_PAD;
          else                      state_q <= ST_DIGIT;
        end
        ST_SIGN: begin
          if (slot_free) begin
            out_char_q  <= CHAR_MINUS;
            out_last_q  <= 1'b0;
            state_q     <= (zeros_q != '0) ? ST_PAD : ST_DIGIT;
          end
        end
        ST_PAD: begin
          if (slot_free) begin
            out_char_q  <= CHAR_ZERO;
            out_last_q  <= 1'b0;
            zeros_q     <= zeros_q - PAD_W'(1);
            if (zeros_q == PAD_W'(1)) state_q <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (slot_free) begin
            out_char_q  <= CHAR_ZERO + CHAR_W'(top_digit);
            out_last_q  <= (ndig_q == NDIG_W'(1));
            ndig_q      <= ndig_q - NDIG_W'(1);
            if (ndig_q == NDIG_W'(1)) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // No carry may leave the top cell: the chain is sized for any magnitude.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV |-> !carry[NDIG])
    else $error("digit chain overflow");

  // Every emitted digit is a valid BCD digit.
  a_bcd_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGIT |-> top_digit <= 4'd9)
    else $error("non-decimal digit at chain top");

  // After alignment the top digit is significant unless the number is zero.
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PREP |-> (top_digit != 4'd0 || ndig_q == NDIG_W'(1)))
    else $error("leading zero left after alignment");

  // Digit count never runs out while digits remain to be sent.
  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT || state_q == ST_PREP) |-> ndig_q != '0)
    else $error("digit count underflow");

endmodule
`default_nettype wire
